FILE: src/ttw_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the
// text terminal writer. No dependencies; every other file in src but ttw_ram uses it.
`default_nettype none

package ttw_pkg;

   // Default screen geometry, used as top-level parameter defaults.
   localparam int SCREEN_WIDTH  = 80;
   localparam int SCREEN_HEIGHT = 25;

   // Fixed field widths of the request and response channels.
   localparam int OPCODE_W = 3;
   localparam int CHAR_W   = 8;
   localparam int COL_IN_W = 7;
   localparam int ROW_IN_W = 5;
   localparam int ATTR_W   = 8;
   localparam int CELL_W   = 16;
   localparam int INDEX_W  = 11;

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_PRINT  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUT    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_SETCUR = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;

   // Character codes with special meaning when printed.
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   // Attribute after reset; the screen is blanked with it as well.
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h1F;

   // A tab prints this many spaces.
   localparam int TAB_SPACES = 4;
   localparam int REM_W      = $clog2(TAB_SPACES);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;      // latch the accepted request
      logic load_rsp;     // load the response register
      logic wr_put;       // write request character at request cell
      logic wr_cur;       // write a character at the cursor cell
      logic emit_space;   // the character for wr_cur is a space
      logic fill;         // write a blank at the sweep address
      logic fill_reset;   // blank uses the reset attribute
      logic rd_cell;      // read the request cell
      logic cap_data;     // capture the read data
      logic copy_rd;      // scroll copy: read one row below the sweep address
      logic sweep_clr;
      logic sweep_inc;
      logic cur_advance;  // step right, wrapping to the next row
      logic cur_newline;  // column 0 of the next row
      logic cur_back;     // step left, wrapping to the previous row
      logic cur_home;
      logic cur_load;     // cursor from the request cell
      logic set_scrolled;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic ch_nul;
      logic ch_lf;
      logic ch_tab;
      logic ch_bs;
      logic col_zero;
      logic row_zero;
      logic col_last;
      logic row_last;
      logic copy_end;
      logic cells_end;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

FILE: src/ttw_req_if.sv
// Request channel of the text terminal writer: valid, ready and one request.
// Depends on ttw_pkg for the field widths.
`default_nettype none

interface ttw_req_if;
   logic                          valid;
   logic                          ready;
   logic [ttw_pkg::OPCODE_W-1:0]  opcode;
   logic [ttw_pkg::CHAR_W-1:0]    char_code;
   logic [ttw_pkg::COL_IN_W-1:0]  col;
   logic [ttw_pkg::ROW_IN_W-1:0]  row;

   modport source (output valid, output opcode, output char_code, output col,
                   output row, input ready);
   modport sink   (input valid, input opcode, input char_code, input col,
                   input row, output ready);
endinterface

`default_nettype wire

FILE: src/ttw_rsp_if.sv
// Response channel of the text terminal writer: valid, ready and one result.
// Depends on ttw_pkg for the field widths.
`default_nettype none

interface ttw_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ttw_pkg::CELL_W-1:0]   cell_data;
   logic [ttw_pkg::COL_IN_W-1:0] cursor_col;
   logic [ttw_pkg::ROW_IN_W-1:0] cursor_row;
   logic [ttw_pkg::INDEX_W-1:0]  cursor_index;
   logic                         scrolled;

   modport source (output valid, output cell_data, output cursor_col,
                   output cursor_row, output cursor_index, output scrolled,
                   input ready);
   modport sink   (input valid, input cell_data, input cursor_col,
                   input cursor_row, input cursor_index, input scrolled,
                   output ready);
endinterface

`default_nettype wire

FILE: src/text_terminal_writer.sv
// Top level of the text terminal writer: controller, datapath, channel wiring.
// Depends on ttw_pkg, ttw_req_if, ttw_rsp_if, ttw_ctrl and ttw_datapath.
//
//   channel  direction  handshake                 contents
//   req_if   in         valid / ready             opcode, char_code, col, row
//   rsp_if   out        valid / ready             cell_data, cursor, index, scrolled
//   csr      in         csr_wr_en (no ready)      attribute byte
//
// A print writes at the cursor, a tab prints its spaces one by one, and backspace at home
// does nothing. A scroll and a clear each sweep the screen memory one cell a cycle.
// After reset a blanking pass runs with req_if.ready low; a held response stalls
// the block only once the next one is done.
`default_nettype none

module text_terminal_writer #(
   parameter int SCREEN_WIDTH  = ttw_pkg::SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = ttw_pkg::SCREEN_HEIGHT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   ttw_req_if.sink                         req_if,
   ttw_rsp_if.source                       rsp_if,
   input  wire logic                       csr_wr_en,
   input  wire logic [ttw_pkg::ATTR_W-1:0] csr_wr_data
);

   ttw_pkg::cmd_type    cmd;
   ttw_pkg::status_type stat;
   logic                req_ready;

   assign req_if.ready = req_ready;

   // Sequencing of each request.
   ttw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Cursor, screen memory and response register.
   ttw_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_if.opcode),
      .req_char_code    (req_if.char_code),
      .req_col          (req_if.col),
      .req_row          (req_if.row),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_cell_data    (rsp_if.cell_data),
      .rsp_cursor_col   (rsp_if.cursor_col),
      .rsp_cursor_row   (rsp_if.cursor_row),
      .rsp_cursor_index (rsp_if.cursor_index),
      .rsp_scrolled     (rsp_if.scrolled),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

`default_nettype wire

FILE: src/ttw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module ttw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/ttw_datapath.sv
// Datapath of the text terminal writer: request latch, cursor, attribute,
// sweep counter, screen memory port muxing and the response register.
// Depends on ttw_pkg and ttw_ram.
`default_nettype none

module ttw_datapath #(
   parameter int SCREEN_WIDTH  = ttw_pkg::SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = ttw_pkg::SCREEN_HEIGHT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ttw_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [ttw_pkg::CHAR_W-1:0]    req_char_code,
   input  wire logic [ttw_pkg::COL_IN_W-1:0]  req_col,
   input  wire logic [ttw_pkg::ROW_IN_W-1:0]  req_row,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [ttw_pkg::CELL_W-1:0]    rsp_cell_data,
   output      logic [ttw_pkg::COL_IN_W-1:0]  rsp_cursor_col,
   output      logic [ttw_pkg::ROW_IN_W-1:0]  rsp_cursor_row,
   output      logic [ttw_pkg::INDEX_W-1:0]   rsp_cursor_index,
   output      logic                          rsp_scrolled,
   input  wire logic                          csr_wr_en,
   input  wire logic [ttw_pkg::ATTR_W-1:0]    csr_wr_data,
   input  wire ttw_pkg::cmd_type              cmd,
   output      ttw_pkg::status_type           stat
);

   localparam int COL_W     = $clog2(SCREEN_WIDTH);
   localparam int ROW_W     = $clog2(SCREEN_HEIGHT);
   localparam int CELLS     = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int COPY_LAST = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH - 1;

   localparam logic [COL_W-1:0]  COL_MAX    = COL_W'(SCREEN_WIDTH - 1);
   localparam logic [ROW_W-1:0]  ROW_MAX    = ROW_W'(SCREEN_HEIGHT - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_WIDTH);

   logic [ttw_pkg::OPCODE_W-1:0] op_ff, op_in;
   logic [ttw_pkg::CHAR_W-1:0]   ch_ff, ch_in;
   logic [COL_W-1:0]             lcol_ff, lcol_in;
   logic [ROW_W-1:0]             lrow_ff, lrow_in;
   logic [COL_W-1:0]             cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]             cur_row_ff, cur_row_in;
   logic [ttw_pkg::ATTR_W-1:0]   attr_ff, attr_in;
   logic [ADDR_W-1:0]            sweep_ff, sweep_in;
   logic                         copy_wr_ff, copy_wr_in;
   logic [ADDR_W-1:0]            copy_addr_ff, copy_addr_in;
   logic [ttw_pkg::CELL_W-1:0]   data_ff, data_in;
   logic                         scrolled_ff, scrolled_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ttw_pkg::CELL_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [ttw_pkg::COL_IN_W-1:0] rsp_col_ff, rsp_col_in;
   logic [ttw_pkg::ROW_IN_W-1:0] rsp_row_ff, rsp_row_in;
   logic [ttw_pkg::INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic                         rsp_scr_ff, rsp_scr_in;

   logic [COL_W-1:0]             col_clamped;
   logic [ROW_W-1:0]             row_clamped;
   logic [ADDR_W-1:0]            req_addr;
   logic [ADDR_W-1:0]            cur_addr;
   logic [ttw_pkg::CELL_W-1:0]   blank_cell;

   logic                         ram_wr_en;
   logic [ADDR_W-1:0]            ram_wr_addr;
   logic [ttw_pkg::CELL_W-1:0]   ram_wr_data;
   logic                         ram_rd_en;
   logic [ADDR_W-1:0]            ram_rd_addr;
   logic [ttw_pkg::CELL_W-1:0]   ram_rd_data;

   // Clamp the requested cell to the screen.
   assign col_clamped = (32'(req_col) > 32'(SCREEN_WIDTH - 1)) ? COL_MAX : COL_W'(req_col);
   assign row_clamped = (32'(req_row) > 32'(SCREEN_HEIGHT - 1)) ? ROW_MAX : ROW_W'(req_row);

   // Linear addresses of the latched request cell and of the cursor.
   assign req_addr = ADDR_W'(lrow_ff) * ROW_STRIDE + ADDR_W'(lcol_ff);
   assign cur_addr = ADDR_W'(cur_row_ff) * ROW_STRIDE + ADDR_W'(cur_col_ff);

   // Blank cell: reset attribute during the power-up pass, else the current one.
   assign blank_cell = {cmd.fill_reset ? ttw_pkg::ATTR_RESET : attr_ff, ttw_pkg::CHAR_SPACE};

   // Request latch, attribute register and sweep counter.
   always_comb begin
      op_in    = op_ff;
      ch_in    = ch_ff;
      lcol_in  = lcol_ff;
      lrow_in  = lrow_ff;
      if (cmd.capture) begin
         op_in   = req_opcode;
         ch_in   = req_char_code;
         lcol_in = col_clamped;
         lrow_in = row_clamped;
      end
      attr_in = csr_wr_en ? csr_wr_data : attr_ff;
      sweep_in = sweep_ff;
      if (cmd.sweep_clr) begin
         sweep_in = '0;
      end else if (cmd.sweep_inc) begin
         sweep_in = sweep_ff + ADDR_W'(1);
      end
   end

   // Cursor update.
   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      if (cmd.cur_home) begin
         cur_col_in = '0;
         cur_row_in = '0;
      end else if (cmd.cur_load) begin
         cur_col_in = lcol_ff;
         cur_row_in = lrow_ff;
      end else if (cmd.cur_advance) begin
         if (cur_col_ff == COL_MAX) begin
            cur_col_in = '0;
            // On the bottom row the row stays; the scroll makes room.
            if (cur_row_ff != ROW_MAX) begin
               cur_row_in = cur_row_ff + ROW_W'(1);
            end
         end else begin
            cur_col_in = cur_col_ff + COL_W'(1);
         end
      end else if (cmd.cur_newline) begin
         cur_col_in = '0;
         if (cur_row_ff != ROW_MAX) begin
            cur_row_in = cur_row_ff + ROW_W'(1);
         end
      end else if (cmd.cur_back) begin
         if (cur_col_ff == '0) begin
            cur_col_in = COL_MAX;
            cur_row_in = cur_row_ff - ROW_W'(1);
         end else begin
            cur_col_in = cur_col_ff - COL_W'(1);
         end
      end
   end

   // Screen memory ports. The scroll copy writes in the cycle after its read.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_addr;
      ram_wr_data = {attr_ff, ch_ff};
      if (copy_wr_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = copy_addr_ff;
         ram_wr_data = ram_rd_data;
      end else if (cmd.fill) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = sweep_ff;
         ram_wr_data = blank_cell;
      end else if (cmd.wr_put) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = req_addr;
         ram_wr_data = {attr_ff, ch_ff};
      end else if (cmd.wr_cur) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = cur_addr;
         ram_wr_data = {attr_ff, cmd.emit_space ? ttw_pkg::CHAR_SPACE : ch_ff};
      end
      ram_rd_en    = cmd.copy_rd | cmd.rd_cell;
      ram_rd_addr  = cmd.copy_rd ? (sweep_ff + ROW_STRIDE) : req_addr;
      copy_wr_in   = cmd.copy_rd;
      copy_addr_in = sweep_ff;
   end

   // Per-request result fields.
   always_comb begin
      data_in     = data_ff;
      scrolled_in = scrolled_ff;
      if (cmd.capture) begin
         data_in     = '0;
         scrolled_in = 1'b0;
      end else begin
         if (cmd.cap_data) begin
            data_in = ram_rd_data;
         end
         if (cmd.set_scrolled) begin
            scrolled_in = 1'b1;
         end
      end
   end

   // Response register; a held response is replaced as it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_index_in = rsp_index_ff;
      rsp_scr_in   = rsp_scr_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = data_ff;
         rsp_col_in   = ttw_pkg::COL_IN_W'(cur_col_ff);
         rsp_row_in   = ttw_pkg::ROW_IN_W'(cur_row_ff);
         rsp_index_in = ttw_pkg::INDEX_W'(cur_addr);
         rsp_scr_in   = scrolled_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         attr_ff      <= ttw_pkg::ATTR_RESET;
         sweep_ff     <= '0;
         copy_wr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         attr_ff      <= attr_in;
         sweep_ff     <= sweep_in;
         copy_wr_ff   <= copy_wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ch_ff        <= ch_in;
      lcol_ff      <= lcol_in;
      lrow_ff      <= lrow_in;
      copy_addr_ff <= copy_addr_in;
      data_ff      <= data_in;
      scrolled_ff  <= scrolled_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_index_ff <= rsp_index_in;
      rsp_scr_ff   <= rsp_scr_in;
   end

   ttw_ram #(
      .WIDTH (ttw_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Status to the controller.
   assign stat.op        = op_ff;
   assign stat.ch_nul    = (ch_ff == ttw_pkg::CHAR_NUL);
   assign stat.ch_lf     = (ch_ff == ttw_pkg::CHAR_LF);
   assign stat.ch_tab    = (ch_ff == ttw_pkg::CHAR_TAB);
   assign stat.ch_bs     = (ch_ff == ttw_pkg::CHAR_BS);
   assign stat.col_zero  = (cur_col_ff == '0);
   assign stat.row_zero  = (cur_row_ff == '0);
   assign stat.col_last  = (cur_col_ff == COL_MAX);
   assign stat.row_last  = (cur_row_ff == ROW_MAX);
   assign stat.copy_end  = (sweep_ff == ADDR_W'(COPY_LAST));
   assign stat.cells_end = (sweep_ff == ADDR_W'(CELLS - 1));
   assign stat.rsp_free  = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_data    = rsp_data_ff;
   assign rsp_cursor_col   = rsp_col_ff;
   assign rsp_cursor_row   = rsp_row_ff;
   assign rsp_cursor_index = rsp_index_ff;
   assign rsp_scrolled     = rsp_scr_ff;

endmodule

`default_nettype wire

FILE: src/ttw_ctrl.sv
// Controller state machine of the text terminal writer: request decode,
// print sequencing, tab repeat, scroll and clear sweeps.
// Depends on ttw_pkg.
`default_nettype none

module ttw_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire ttw_pkg::status_type stat,
   output      ttw_pkg::cmd_type    cmd
);

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] S_INIT      = 4'd0;
   localparam logic [STATE_W-1:0] S_IDLE      = 4'd1;
   localparam logic [STATE_W-1:0] S_EXEC      = 4'd2;
   localparam logic [STATE_W-1:0] S_EMIT      = 4'd3;
   localparam logic [STATE_W-1:0] S_BS_WR     = 4'd4;
   localparam logic [STATE_W-1:0] S_READ_WAIT = 4'd5;
   localparam logic [STATE_W-1:0] S_CLEAR     = 4'd6;
   localparam logic [STATE_W-1:0] S_SCR_COPY  = 4'd7;
   localparam logic [STATE_W-1:0] S_SCR_DRAIN = 4'd8;
   localparam logic [STATE_W-1:0] S_SCR_BLANK = 4'd9;
   localparam logic [STATE_W-1:0] S_DONE      = 4'd10;

   localparam logic [ttw_pkg::REM_W-1:0] TAB_REM = ttw_pkg::REM_W'(ttw_pkg::TAB_SPACES - 1);

   logic [STATE_W-1:0]        state_ff, state_in;
   logic [ttw_pkg::REM_W-1:0] rem_ff, rem_in;   // spaces still to print after this one

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            // Power-up pass: blank every cell with the reset attribute.
            cmd.fill       = 1'b1;
            cmd.fill_reset = 1'b1;
            cmd.sweep_inc  = 1'b1;
            if (stat.cells_end) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rem_in   = '0;
            state_in = S_DONE;
            unique case (stat.op)
               ttw_pkg::OP_PRINT: begin
                  if (stat.ch_nul) begin
                     state_in = S_DONE;
                  end else if (stat.ch_lf) begin
                     cmd.cur_newline = 1'b1;
                     if (stat.row_last) begin
                        cmd.sweep_clr    = 1'b1;
                        cmd.set_scrolled = 1'b1;
                        state_in         = S_SCR_COPY;
                     end
                  end else if (stat.ch_bs) begin
                     // Backspace at the top-left cell does nothing.
                     if (!(stat.col_zero && stat.row_zero)) begin
                        cmd.cur_back = 1'b1;
                        state_in     = S_BS_WR;
                     end
                  end else begin
                     if (stat.ch_tab) begin
                        rem_in = TAB_REM;
                     end
                     state_in = S_EMIT;
                  end
               end
               ttw_pkg::OP_PUT: begin
                  cmd.wr_put = 1'b1;
               end
               ttw_pkg::OP_CLEAR: begin
                  cmd.cur_home  = 1'b1;
                  cmd.sweep_clr = 1'b1;
                  state_in      = S_CLEAR;
               end
               ttw_pkg::OP_SETCUR: begin
                  cmd.cur_load = 1'b1;
               end
               ttw_pkg::OP_READ: begin
                  cmd.rd_cell = 1'b1;
                  state_in    = S_READ_WAIT;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_EMIT: begin
            // Write one character at the cursor and step right.
            cmd.wr_cur      = 1'b1;
            cmd.emit_space  = stat.ch_tab;
            cmd.cur_advance = 1'b1;
            if (stat.col_last && stat.row_last) begin
               cmd.sweep_clr    = 1'b1;
               cmd.set_scrolled = 1'b1;
               state_in         = S_SCR_COPY;
            end else if (rem_ff != '0) begin
               rem_in = rem_ff - ttw_pkg::REM_W'(1);
            end else begin
               state_in = S_DONE;
            end
         end
         S_BS_WR: begin
            cmd.wr_cur     = 1'b1;
            cmd.emit_space = 1'b1;
            state_in       = S_DONE;
         end
         S_READ_WAIT: begin
            cmd.cap_data = 1'b1;
            state_in     = S_DONE;
         end
         S_CLEAR: begin
            cmd.fill      = 1'b1;
            cmd.sweep_inc = 1'b1;
            if (stat.cells_end) begin
               state_in = S_DONE;
            end
         end
         S_SCR_COPY: begin
            // Move every row but the first up by one, one cell a cycle.
            cmd.copy_rd   = 1'b1;
            cmd.sweep_inc = 1'b1;
            if (stat.copy_end) begin
               state_in = S_SCR_DRAIN;
            end
         end
         S_SCR_DRAIN: begin
            // The last copied cell is written in this cycle.
            state_in = S_SCR_BLANK;
         end
         S_SCR_BLANK: begin
            cmd.fill      = 1'b1;
            cmd.sweep_inc = 1'b1;
            if (stat.cells_end) begin
               // Resume a tab that still has spaces to print.
               if (rem_ff != '0) begin
                  rem_in   = rem_ff - ttw_pkg::REM_W'(1);
                  state_in = S_EMIT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
      end
   end

   // The delayed scroll copy write must never meet another memory write.
   a_copy_write_alone: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.copy_rd) |-> !(cmd.fill || cmd.wr_cur || cmd.wr_put))
      else $error("scroll copy write collides with another write");

   // A response is loaded only when the response register can take it.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> stat.rsp_free)
      else $error("response loaded over an untaken response");

   // An accepted request is decoded in the following cycle.
   a_capture_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == S_EXEC)
      else $error("accepted request not decoded");

   // No request is taken while the power-up blanking pass runs.
   a_no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INIT |-> !req_ready)
      else $error("request accepted during power-up blanking");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the text terminal writer: directed table, then random requests.
// Depends on ttw_pkg, ttw_req_if, ttw_rsp_if and text_terminal_writer from src.
// A bench screen model predicts each untyped response; a monitor compares all of them in order.
`timescale 1ns / 100ps

module tb;

   localparam int SCR_W        = ttw_pkg::SCREEN_WIDTH;
   localparam int SCR_H        = ttw_pkg::SCREEN_HEIGHT;
   localparam int CELLS        = SCR_W * SCR_H;
   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 4;
   localparam int PHASE_ITEMS  = 340;
   localparam int HOLD_ITEMS   = 40;
   localparam int HOLD_CYCLES  = 500;
   localparam int TAIL_CYCLES  = CELLS + 100;
   localparam int LIMIT_CYCLES = 12_000_000;

   // Opcodes that the block does not define.
   localparam logic [ttw_pkg::OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [ttw_pkg::OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [ttw_pkg::OPCODE_W-1:0] opcode;
      logic [ttw_pkg::CHAR_W-1:0]   char_code;
      logic [ttw_pkg::COL_IN_W-1:0] col;
      logic [ttw_pkg::ROW_IN_W-1:0] row;
   } term_req_type;

   typedef struct packed {
      logic [ttw_pkg::CELL_W-1:0]   cell_data;
      logic [ttw_pkg::COL_IN_W-1:0] cursor_col;
      logic [ttw_pkg::ROW_IN_W-1:0] cursor_row;
      logic [ttw_pkg::INDEX_W-1:0]  cursor_index;
      logic                         scrolled;
   } term_rsp_type;

   typedef struct {
      term_req_type req;
      bit           typed;
      term_rsp_type rsp;
   } table_row_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [ttw_pkg::ATTR_W-1:0] csr_wr_data;

   ttw_req_if req_if ();
   ttw_rsp_if rsp_if ();

   text_terminal_writer dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Screen model: cells, cursor and the attribute register.
   logic [ttw_pkg::CELL_W-1:0]   screen_model [CELLS];
   logic [ttw_pkg::COL_IN_W-1:0] model_col;
   logic [ttw_pkg::ROW_IN_W-1:0] model_row;
   logic [ttw_pkg::ATTR_W-1:0]   model_attr;

   term_rsp_type  pending_rsp [$];
   table_row_type directed_rows [$];

   int  send_idle_pct;
   int  rsp_stall_pct;
   bit  hold_phase;
   bit  hold_taken;
   int  hold_left;
   int  cycle_count;
   int  mismatch_count;
   int  accepted_count;
   int  checked_count;
   int  scroll_count;
   int  attr_settings;

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // The whole run is bounded by a cycle budget.
   initial begin
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [ttw_pkg::CELL_W-1:0] cell_of(
      input logic [ttw_pkg::CHAR_W-1:0] ch);
      return {model_attr, ch};
   endfunction

   function automatic void blank_screen();
      for (int i = 0; i < CELLS; i++) screen_model[i] = cell_of(ttw_pkg::CHAR_SPACE);
   endfunction

   // Moving past the bottom row shifts everything up one row and blanks the last.
   function automatic bit scroll_if_past();
      int i;
      if (model_row < SCR_H) return 1'b0;
      for (i = 0; i < (SCR_H - 1) * SCR_W; i++) screen_model[i] = screen_model[i + SCR_W];
      for (; i < CELLS; i++) screen_model[i] = cell_of(ttw_pkg::CHAR_SPACE);
      model_row = ttw_pkg::ROW_IN_W'(SCR_H - 1);
      model_col = '0;
      return 1'b1;
   endfunction

   function automatic bit put_at_cursor(input logic [ttw_pkg::CHAR_W-1:0] ch);
      screen_model[model_row * SCR_W + model_col] = cell_of(ch);
      model_col++;
      if (model_col >= SCR_W) begin
         model_col = '0;
         model_row++;
      end
      return scroll_if_past();
   endfunction

   // Applies one request to the screen model and returns the response it causes.
   function automatic term_rsp_type apply_request(input term_req_type r);
      term_rsp_type rsp;
      int           c;
      int           rw;
      bit           sc;
      c   = (r.col > SCR_W - 1) ? SCR_W - 1 : r.col;
      rw  = (r.row > SCR_H - 1) ? SCR_H - 1 : r.row;
      sc  = 1'b0;
      rsp = '0;
      case (r.opcode)
         ttw_pkg::OP_PRINT: begin
            case (r.char_code)
               ttw_pkg::CHAR_NUL: ;
               ttw_pkg::CHAR_LF: begin
                  model_row++;
                  model_col = '0;
                  sc = scroll_if_past();
               end
               ttw_pkg::CHAR_TAB: begin
                  for (int k = 0; k < ttw_pkg::TAB_SPACES; k++)
                     if (put_at_cursor(ttw_pkg::CHAR_SPACE)) sc = 1'b1;
               end
               ttw_pkg::CHAR_BS: begin
                  // Backspace at the home cell does nothing at all.
                  if (!(model_col == 0 && model_row == 0)) begin
                     if (model_col == 0) begin
                        model_row--;
                        model_col = ttw_pkg::COL_IN_W'(SCR_W - 1);
                     end else begin
                        model_col--;
                     end
                     screen_model[model_row * SCR_W + model_col] =
                        cell_of(ttw_pkg::CHAR_SPACE);
                     sc = scroll_if_past();
                  end
               end
               default: sc = put_at_cursor(r.char_code);
            endcase
         end
         ttw_pkg::OP_PUT: screen_model[rw * SCR_W + c] = cell_of(r.char_code);
         ttw_pkg::OP_CLEAR: begin
            blank_screen();
            model_col = '0;
            model_row = '0;
         end
         ttw_pkg::OP_SETCUR: begin
            model_col = ttw_pkg::COL_IN_W'(c);
            model_row = ttw_pkg::ROW_IN_W'(rw);
         end
         ttw_pkg::OP_READ: rsp.cell_data = screen_model[rw * SCR_W + c];
         default: ;
      endcase
      rsp.cursor_col   = model_col;
      rsp.cursor_row   = model_row;
      rsp.cursor_index = ttw_pkg::INDEX_W'(model_row * SCR_W + model_col);
      rsp.scrolled     = sc;
      if (sc) scroll_count++;
      return rsp;
   endfunction

   function automatic void add_row(input logic [ttw_pkg::OPCODE_W-1:0] op,
                                   input logic [ttw_pkg::CHAR_W-1:0]   ch,
                                   input logic [ttw_pkg::COL_IN_W-1:0] col,
                                   input logic [ttw_pkg::ROW_IN_W-1:0] row,
                                   input bit typed,
                                   input logic [ttw_pkg::CELL_W-1:0]   cell_value,
                                   input int ccol, input int crow, input bit sc);
      table_row_type t;
      t.req   = '{opcode: op, char_code: ch, col: col, row: row};
      t.typed = typed;
      t.rsp   = '{cell_data: cell_value,
                  cursor_col: ttw_pkg::COL_IN_W'(ccol),
                  cursor_row: ttw_pkg::ROW_IN_W'(crow),
                  cursor_index: ttw_pkg::INDEX_W'(crow * SCR_W + ccol),
                  scrolled: sc};
      directed_rows.push_back(t);
   endfunction

   // Random request mix; the largest share of it prints text, with reads often aimed near the cursor.
   function automatic term_req_type random_request();
      term_req_type r;
      int           pick;
      int           sel;
      int           c;
      r.char_code = ttw_pkg::CHAR_W'($urandom_range(255));
      r.col       = ttw_pkg::COL_IN_W'($urandom_range(127));
      r.row       = ttw_pkg::ROW_IN_W'($urandom_range(31));
      pick        = $urandom_range(99);
      if (pick < 48) begin
         r.opcode = ttw_pkg::OP_PRINT;
         sel = $urandom_range(99);
         if (sel < 8) r.char_code = ttw_pkg::CHAR_LF;
         else if (sel < 14) r.char_code = ttw_pkg::CHAR_TAB;
         else if (sel < 24) r.char_code = ttw_pkg::CHAR_BS;
         else if (sel < 28) r.char_code = ttw_pkg::CHAR_NUL;
         else if (sel < 75) r.char_code = ttw_pkg::CHAR_W'($urandom_range(8'h7E, 8'h20));
      end else if (pick < 62) begin
         r.opcode = ttw_pkg::OP_PUT;
      end else if (pick < 63) begin
         r.opcode = ttw_pkg::OP_CLEAR;
      end else if (pick < 75) begin
         r.opcode = ttw_pkg::OP_SETCUR;
         if ($urandom_range(99) < 30)
            r.row = ttw_pkg::ROW_IN_W'($urandom_range(31, SCR_H - 2));
      end else if (pick < 95) begin
         r.opcode = ttw_pkg::OP_READ;
         if ($urandom_range(1) == 1) begin
            c     = model_col - $urandom_range(6);
            r.col = (c < 0) ? '0 : ttw_pkg::COL_IN_W'(c);
            r.row = (model_row > 0 && $urandom_range(1) == 1) ?
                    ttw_pkg::ROW_IN_W'(model_row - 1) : model_row;
         end
      end else begin
         r.opcode = ttw_pkg::OPCODE_W'($urandom_range(OP_SPARE_7, OP_SPARE_5));
      end
      return r;
   endfunction

   // Offers one request, waits for it to be taken and records the expected response.
   task automatic send_request(input term_req_type r, input bit typed,
                               input term_rsp_type typed_rsp);
      term_rsp_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid     <= 1'b1;
      req_if.opcode    <= r.opcode;
      req_if.char_code <= r.char_code;
      req_if.col       <= r.col;
      req_if.row       <= r.row;
      do @(posedge clock); while (!req_if.ready);
      predicted = apply_request(r);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      accepted_count++;
   endtask

   // The sender stops until every outstanding response has come back.
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic write_attribute(input logic [ttw_pkg::ATTR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      model_attr = value;
      csr_wr_en <= 1'b0;
      attr_settings++;
   endtask

   // Response side: random stalls, plus one long hold-off when asked for.
   always @(posedge clock) begin
      if (hold_phase && !hold_taken) begin
         hold_taken   <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
      if (!hold_phase) hold_taken <= 1'b0;
   end

   // Each accepted response is compared with the oldest expectation.
   always @(posedge clock) begin : check_rsp
      term_rsp_type want;
      if (rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response arrived with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_rsp.pop_front();
            checked_count++;
            if (rsp_if.cell_data !== want.cell_data) begin
               $error("cell_data: expected %h, got %h", want.cell_data, rsp_if.cell_data);
               mismatch_count++;
            end
            if (rsp_if.cursor_col !== want.cursor_col) begin
               $error("cursor_col: expected %0d, got %0d", want.cursor_col, rsp_if.cursor_col);
               mismatch_count++;
            end
            if (rsp_if.cursor_row !== want.cursor_row) begin
               $error("cursor_row: expected %0d, got %0d", want.cursor_row, rsp_if.cursor_row);
               mismatch_count++;
            end
            if (rsp_if.cursor_index !== want.cursor_index) begin
               $error("cursor_index: expected %0d, got %0d",
                      want.cursor_index, rsp_if.cursor_index);
               mismatch_count++;
            end
            if (rsp_if.scrolled !== want.scrolled) begin
               $error("scrolled: expected %0d, got %0d", want.scrolled, rsp_if.scrolled);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int send_pct_by_phase [4];
      int recv_pct_by_phase [4];
      send_pct_by_phase = '{0, 66, 0, 33};
      recv_pct_by_phase = '{0, 0, 66, 33};

      clock            = 1'b0;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_if.valid     = 1'b0;
      req_if.opcode    = ttw_pkg::OP_PRINT;
      req_if.char_code = '0;
      req_if.col       = '0;
      req_if.row       = '0;
      rsp_if.ready     = 1'b0;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      hold_phase       = 1'b0;
      hold_taken       = 1'b0;
      hold_left        = 0;
      cycle_count      = 0;
      mismatch_count   = 0;
      accepted_count   = 0;
      checked_count    = 0;
      scroll_count     = 0;
      attr_settings    = 0;

      model_attr = ttw_pkg::ATTR_RESET;
      blank_screen();
      model_col = '0;
      model_row = '0;

      // Directed table. Typed rows follow straight from reset, extremes and clamping.
      add_row(ttw_pkg::OP_READ,   8'h00,             7'd0,   5'd0,  1, 16'h1F20, 0,  0,  0);
      add_row(ttw_pkg::OP_READ,   8'h00,             7'd127, 5'd31, 1, 16'h1F20, 0,  0,  0);
      add_row(ttw_pkg::OP_PRINT,  ttw_pkg::CHAR_BS,  7'd0,   5'd0,  1, 16'h0000, 0,  0,  0);
      add_row(ttw_pkg::OP_PRINT,  ttw_pkg::CHAR_NUL, 7'd0,   5'd0,  1, 16'h0000, 0,  0,  0);
      add_row(ttw_pkg::OP_PRINT,  8'h41,             7'd0,   5'd0,  0, '0,       0,  0,  0);
      add_row(ttw_pkg::OP_PRINT,  8'hFF,             7'd0,   5'd0,  0, '0,       0,  0,  0);
      add_row(ttw_pkg::OP_READ,   8'h00,             7'd1,   5'd0,  1, 16'h1FFF, 2,  0,  0);
      add_row(ttw_pkg::OP_PRINT,  ttw_pkg::CHAR_TAB, 7'd0,   5'd0,  0, '0,       0,  0,  0);
      add_row(ttw_pkg::OP_PRINT,  ttw_pkg::CHAR_BS,  7'd0,   5'd0,  0, '0,       0,  0,  0);
      add_row(ttw_pkg::OP_SETCUR, 8'h00,             7'd127, 5'd31, 1, 16'h0000, 79, 24, 0);
      // A character in the last cell wraps and scrolls; the cell moves up a row.
      add_row(ttw_pkg::OP_PRINT,  8'h5A,             7'd0,   5'd0,  0, '0,       0,  0,  0);
      add_row(ttw_pkg::OP_READ,   8'h00,             7'd79,  5'd23, 0, '0,       0,  0,  0);
      // Backspace at column 0 goes back to the end of the row above.
      add_row(ttw_pkg::OP_PRINT,  ttw_pkg::CHAR_BS,  7'd0,   5'd0,  0, '0,       0,  0,  0);
      add_row(ttw_pkg::OP_READ,   8'h00,             7'd79,  5'd23, 0, '0,       0,  0,  0);
      // Line feed on the bottom row scrolls.
      add_row(ttw_pkg::OP_SETCUR, 8'h00,             7'd0,   5'd24, 0, '0,       0,  0,  0);
      add_row(ttw_pkg::OP_PRINT,  ttw_pkg::CHAR_LF,  7'd0,   5'd0,  0, '0,       0,  0,  0);
      // A tab near the bottom-right corner wraps and scrolls midway.
      add_row(ttw_pkg::OP_SETCUR, 8'h00,             7'd78,  5'd24, 0, '0,       0,  0,  0);
      add_row(ttw_pkg::OP_PRINT,  ttw_pkg::CHAR_TAB, 7'd0,   5'd0,  0, '0,       0,  0,  0);
      // Put stores control bytes as they are, and high bytes stay in the low byte.
      add_row(ttw_pkg::OP_PUT,    ttw_pkg::CHAR_NUL, 7'd5,   5'd3,  0, '0,       0,  0,  0);
      add_row(ttw_pkg::OP_READ,   8'h00,             7'd5,   5'd3,  0, '0,       0,  0,  0);
      add_row(ttw_pkg::OP_PUT,    8'h80,             7'd127, 5'd31, 0, '0,       0,  0,  0);
      add_row(ttw_pkg::OP_READ,   8'h00,             7'd127, 5'd31, 0, '0,       0,  0,  0);
      add_row(OP_SPARE_5,         8'h00,             7'd0,   5'd0,  0, '0,       0,  0,  0);
      add_row(OP_SPARE_7,         8'hFF,             7'd127, 5'd31, 0, '0,       0,  0,  0);
      add_row(ttw_pkg::OP_CLEAR,  8'h00,             7'd0,   5'd0,  1, 16'h0000, 0,  0,  0);
      add_row(ttw_pkg::OP_READ,   8'h00,             7'd79,  5'd24, 1, 16'h1F20, 0,  0,  0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      drain_responses();

      // Random phases, each under its own attribute and idle pattern.
      for (int p = 0; p < 4; p++) begin
         write_attribute(p == 0 ? 8'h00 :
                         (p == 1 ? 8'hFF : ttw_pkg::ATTR_W'($urandom_range(255))));
         send_idle_pct = send_pct_by_phase[p];
         rsp_stall_pct <= recv_pct_by_phase[p];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 3 && $urandom_range(49) == 0) drain_responses();
            send_request(random_request(), 1'b0, '0);
         end
         drain_responses();
      end

      // Long response hold-off while requests keep coming, so the input backs up.
      write_attribute(ttw_pkg::ATTR_W'($urandom_range(255)));
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      hold_phase    <= 1'b1;
      for (int n = 0; n < HOLD_ITEMS; n++) send_request(random_request(), 1'b0, '0);
      hold_phase <= 1'b0;
      drain_responses();

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d requests (%0d scrolling) under %0d attribute settings,",
               accepted_count, scroll_count, attr_settings + 1);
      $display("with four idle patterns and one long response hold-off; %0d responses checked.",
               checked_count);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
